FILE: hw/rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types for the token scanner: modes, character classes, token kinds,
// error codes, the classified item and the result record.
// ----------------------------------------------------------------------------
package cts_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_PIPE, M_NUM, M_IDENT,
    M_LINEC, M_BLOCK, M_BSTAR, M_BSLASH
  } mode_t;

  typedef enum logic [3:0] {
    CL_SINGLE, CL_STAR, CL_SLASH, CL_EQ, CL_BANG, CL_LT, CL_GT, CL_AMP,
    CL_PIPE, CL_DIGIT, CL_ALPHA, CL_BLANK, CL_NEWLINE, CL_BAD
  } cls_t;

  typedef enum logic [4:0] {
    K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_COMMA, K_SEMI, K_PLUS, K_MINUS,
    K_STAR, K_DIV, K_MOD, K_ASSIGN, K_EQ, K_NOT, K_NE, K_LT, K_LE, K_GT, K_GE,
    K_AND, K_OR, K_NUMBER, K_IDENT, K_END
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE, E_BAD_CHAR, E_LONE_AMP_PIPE, E_OVERFLOW, E_UNTERMINATED, E_NESTING
  } err_t;

  typedef struct packed {
    logic       eos;
    cls_t       cls;
    kind_t      kind;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    kind_t       token_kind;
    err_t        error_code;
    logic [15:0] start_line;
    logic [11:0] start_column;
    logic [15:0] token_length;
    logic [30:0] number_value;
    logic        last_of_run;
  } res_t;

endpackage

FILE: hw/rtl/cts_fifo.sv
// ----------------------------------------------------------------------------
// cts_fifo
// Small register queue with two write lanes and one read port; lane one must
// write only together with lane zero (not enforced), into the slot after it.
// ----------------------------------------------------------------------------
module cts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en0,
  input  logic [WIDTH-1:0]             wr_data0,
  input  logic                         wr_en1,
  input  logic [WIDTH-1:0]             wr_data1,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr1;
  logic [CW-1:0]    count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr_r);
  assign rd_data = mem_r[rd_ptr_r];
  assign count   = count_r;

  always_comb begin
    count_nxt = count_r + CW'(wr_en0) + CW'(wr_en1) - CW'(rd_en);
    if (wr_en1) begin
      wr_ptr_nxt = ptr_inc(wr_ptr1);
    end else if (wr_en0) begin
      wr_ptr_nxt = wr_ptr1;
    end else begin
      wr_ptr_nxt = wr_ptr_r;
    end
    rd_ptr_nxt = rd_en ? ptr_inc(rd_ptr_r) : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en0) begin
      mem_r[wr_ptr_r] <= wr_data0;
    end
    if (wr_en1) begin
      mem_r[wr_ptr1] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_lane_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en1 |-> wr_en0)
    else $error("second write lane used alone");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> count_r != '0)
    else $error("read from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en0 |-> (count_r + CW'(wr_en1)) < CW'(DEPTH))
    else $error("write into full queue");

endmodule

FILE: hw/rtl/cts_front.sv
// ----------------------------------------------------------------------------
// cts_front
// Character classifier: sorts each source byte into the class the scanner
// acts on, with its single-character kind and digit value.
// ----------------------------------------------------------------------------
module cts_front (
  input  logic          [7:0] char_code,
  input  logic                end_of_source,
  output cts_pkg::item_t      item
);
  import cts_pkg::*;

  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  logic [7:0] digit_w;

  assign digit_w = char_code - CH_ZERO;

  always_comb begin
    item.eos   = end_of_source;
    item.cls   = CL_SINGLE;
    item.kind  = K_LPAREN;
    item.digit = digit_w[3:0];
    unique case (char_code)
      CH_LPAREN:  item.kind = K_LPAREN;
      CH_RPAREN:  item.kind = K_RPAREN;
      CH_LBRACE:  item.kind = K_LBRACE;
      CH_RBRACE:  item.kind = K_RBRACE;
      CH_COMMA:   item.kind = K_COMMA;
      CH_SEMI:    item.kind = K_SEMI;
      CH_PLUS:    item.kind = K_PLUS;
      CH_MINUS:   item.kind = K_MINUS;
      CH_PERCENT: item.kind = K_MOD;
      CH_STAR: begin
        item.cls  = CL_STAR;
        item.kind = K_STAR;
      end
      CH_SLASH:   item.cls = CL_SLASH;
      CH_EQUAL:   item.cls = CL_EQ;
      CH_BANG:    item.cls = CL_BANG;
      CH_LESS:    item.cls = CL_LT;
      CH_GREATER: item.cls = CL_GT;
      CH_AMP:     item.cls = CL_AMP;
      CH_BAR:     item.cls = CL_PIPE;
      CH_SPACE, CH_TAB, CH_CR: item.cls = CL_BLANK;
      CH_LF:      item.cls = CL_NEWLINE;
      default: begin
        if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
          item.cls = CL_DIGIT;
        end else if ((char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) ||
                     (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) ||
                     char_code == CH_UNDERSCORE) begin
          item.cls = CL_ALPHA;
        end else begin
          item.cls = CL_BAD;
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/cts_scanner.sv
// ----------------------------------------------------------------------------
// cts_scanner
// Scanner state machine: takes one classified item per step and produces up
// to two token records, tracking line, column, lexeme and comment nesting.
// ----------------------------------------------------------------------------
module cts_scanner #(
  parameter int LINE_BITS         = 16,
  parameter int COLUMN_BITS       = 12,
  parameter int MAX_COMMENT_DEPTH = 255
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  cts_pkg::item_t item,
  input  logic           out_room,
  output logic           item_pop,
  output logic           res0_v,
  output cts_pkg::res_t  res0,
  output logic           res1_v,
  output cts_pkg::res_t  res1
);
  import cts_pkg::*;

  localparam int DW = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [34:0] NUM_MAX = 35'd2147483647;

  mode_t                  mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [COLUMN_BITS-1:0] tsc_r, tsc_nxt;
  logic [15:0]            len_r, len_nxt;
  logic [30:0]            acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic                   halted_r, halted_nxt;

  logic        step;
  logic [31:0] line_w, col_w, tsc_w;
  logic [15:0] line16;
  logic [11:0] col12, tsc12;
  logic [34:0] num_next;
  logic [DW-1:0] depth_dec;

  logic  idle_emit, idle_start, idle_num;
  mode_t idle_mode;
  res_t  idle_res;

  logic  p_v, s_v, apply_idle;
  res_t  p_res, s_res;

  function automatic res_t mk_res(kind_t k, err_t e, logic [15:0] ln, logic [11:0] cl,
                                  logic [15:0] len, logic [30:0] val);
    res_t r;
    r.token_kind   = k;
    r.error_code   = e;
    r.start_line   = ln;
    r.start_column = cl;
    r.token_length = len;
    r.number_value = val;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign step     = item_valid && out_room;
  assign item_pop = step;

  assign line_w = 32'(line_r);
  assign col_w  = 32'(col_r);
  assign tsc_w  = 32'(tsc_r);
  assign line16 = line_w[15:0];
  assign col12  = col_w[11:0];
  assign tsc12  = tsc_w[11:0];

  assign num_next  = (35'(acc_r) << 3) + (35'(acc_r) << 1) + 35'(item.digit);
  assign depth_dec = depth_r - 1'b1;

  // action of a character met between tokens
  always_comb begin
    idle_emit  = 1'b0;
    idle_start = 1'b0;
    idle_num   = 1'b0;
    idle_mode  = M_IDLE;
    idle_res   = mk_res(item.kind, E_NONE, line16, col12, 16'd1, '0);
    unique case (item.cls)
      CL_SINGLE, CL_STAR: idle_emit = 1'b1;
      CL_SLASH: begin idle_start = 1'b1; idle_mode = M_SLASH; end
      CL_EQ:    begin idle_start = 1'b1; idle_mode = M_EQ;    end
      CL_BANG:  begin idle_start = 1'b1; idle_mode = M_BANG;  end
      CL_LT:    begin idle_start = 1'b1; idle_mode = M_LT;    end
      CL_GT:    begin idle_start = 1'b1; idle_mode = M_GT;    end
      CL_AMP:   begin idle_start = 1'b1; idle_mode = M_AMP;   end
      CL_PIPE:  begin idle_start = 1'b1; idle_mode = M_PIPE;  end
      CL_DIGIT: begin
        idle_start = 1'b1;
        idle_num   = 1'b1;
        idle_mode  = M_NUM;
      end
      CL_ALPHA: begin idle_start = 1'b1; idle_mode = M_IDENT; end
      CL_BLANK, CL_NEWLINE: ;
      CL_BAD: begin
        idle_emit = 1'b1;
        idle_res  = mk_res(K_LPAREN, E_BAD_CHAR, line16, col12, 16'd1, '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    tsc_nxt    = tsc_r;
    len_nxt    = len_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    depth_nxt  = depth_r;
    halted_nxt = halted_r;
    p_v        = 1'b0;
    s_v        = 1'b0;
    apply_idle = 1'b0;
    p_res      = mk_res(K_LPAREN, E_NONE, line16, tsc12, 16'd1, '0);
    s_res      = mk_res(K_END, E_NONE, line16, col12, 16'd1, '0);

    if (step && item.eos) begin
      if (!halted_r) begin
        unique case (mode_r)
          M_SLASH: begin p_v = 1'b1; p_res.token_kind = K_DIV;    end
          M_EQ:    begin p_v = 1'b1; p_res.token_kind = K_ASSIGN; end
          M_BANG:  begin p_v = 1'b1; p_res.token_kind = K_NOT;    end
          M_LT:    begin p_v = 1'b1; p_res.token_kind = K_LT;     end
          M_GT:    begin p_v = 1'b1; p_res.token_kind = K_GT;     end
          M_AMP, M_PIPE: begin
            p_v = 1'b1;
            p_res.error_code = E_LONE_AMP_PIPE;
          end
          M_NUM: begin
            p_v = 1'b1;
            p_res = ovf_r ? mk_res(K_LPAREN, E_OVERFLOW, line16, tsc12, len_r, '0)
                          : mk_res(K_NUMBER, E_NONE, line16, tsc12, len_r, acc_r);
          end
          M_IDENT: begin
            p_v = 1'b1;
            p_res = mk_res(K_IDENT, E_NONE, line16, tsc12, len_r, '0);
          end
          M_BLOCK, M_BSTAR, M_BSLASH: begin
            p_v = 1'b1;
            p_res = mk_res(K_LPAREN, E_UNTERMINATED, line16, col12, 16'd1, '0);
          end
          default: ;
        endcase
      end
      s_v        = 1'b1;
      mode_nxt   = M_IDLE;
      line_nxt   = LINE_BITS'(1);
      col_nxt    = COLUMN_BITS'(1);
      tsc_nxt    = COLUMN_BITS'(1);
      len_nxt    = '0;
      acc_nxt    = '0;
      ovf_nxt    = 1'b0;
      depth_nxt  = '0;
      halted_nxt = 1'b0;
    end else if (step && !halted_r) begin
      unique case (mode_r)
        M_SLASH: begin
          if (item.cls == CL_SLASH) begin
            mode_nxt = M_LINEC;
          end else if (item.cls == CL_STAR) begin
            depth_nxt = DW'(1);
            mode_nxt  = M_BLOCK;
          end else begin
            mode_nxt = M_IDLE;
            p_v = 1'b1;
            p_res.token_kind = K_DIV;
            apply_idle = 1'b1;
          end
        end
        M_EQ, M_BANG, M_LT, M_GT: begin
          mode_nxt = M_IDLE;
          p_v = 1'b1;
          if (item.cls == CL_EQ) begin
            p_res.token_length = 16'd2;
            unique case (mode_r)
              M_EQ:    p_res.token_kind = K_EQ;
              M_BANG:  p_res.token_kind = K_NE;
              M_LT:    p_res.token_kind = K_LE;
              default: p_res.token_kind = K_GE;
            endcase
          end else begin
            unique case (mode_r)
              M_EQ:    p_res.token_kind = K_ASSIGN;
              M_BANG:  p_res.token_kind = K_NOT;
              M_LT:    p_res.token_kind = K_LT;
              default: p_res.token_kind = K_GT;
            endcase
            apply_idle = 1'b1;
          end
        end
        M_AMP, M_PIPE: begin
          mode_nxt = M_IDLE;
          p_v = 1'b1;
          if (mode_r == M_AMP && item.cls == CL_AMP) begin
            p_res.token_kind   = K_AND;
            p_res.token_length = 16'd2;
          end else if (mode_r == M_PIPE && item.cls == CL_PIPE) begin
            p_res.token_kind   = K_OR;
            p_res.token_length = 16'd2;
          end else begin
            p_res.error_code = E_LONE_AMP_PIPE;
          end
        end
        M_NUM: begin
          if (item.cls == CL_DIGIT) begin
            if (len_r != 16'hFFFF) begin
              len_nxt = len_r + 16'd1;
            end
            if (num_next > NUM_MAX) begin
              ovf_nxt = 1'b1;
            end else if (!ovf_r) begin
              acc_nxt = num_next[30:0];
            end
          end else begin
            mode_nxt = M_IDLE;
            p_v = 1'b1;
            if (ovf_r) begin
              p_res = mk_res(K_LPAREN, E_OVERFLOW, line16, tsc12, len_r, '0);
            end else begin
              p_res = mk_res(K_NUMBER, E_NONE, line16, tsc12, len_r, acc_r);
              apply_idle = 1'b1;
            end
          end
        end
        M_IDENT: begin
          if (item.cls == CL_ALPHA || item.cls == CL_DIGIT) begin
            if (len_r != 16'hFFFF) begin
              len_nxt = len_r + 16'd1;
            end
          end else begin
            mode_nxt = M_IDLE;
            p_v = 1'b1;
            p_res = mk_res(K_IDENT, E_NONE, line16, tsc12, len_r, '0);
            apply_idle = 1'b1;
          end
        end
        M_LINEC: begin
          if (item.cls == CL_NEWLINE) begin
            mode_nxt = M_IDLE;
          end
        end
        M_BSTAR: begin
          if (item.cls == CL_SLASH) begin
            depth_nxt = depth_dec;
            mode_nxt  = (depth_dec == '0) ? M_IDLE : M_BLOCK;
          end else if (item.cls == CL_STAR) begin
            mode_nxt = M_BSTAR;
          end else begin
            mode_nxt = M_BLOCK;
          end
        end
        M_BSLASH: begin
          if (item.cls == CL_STAR) begin
            if (depth_r >= DW'(MAX_COMMENT_DEPTH)) begin
              p_v = 1'b1;
              p_res = mk_res(K_LPAREN, E_NESTING, line16, col12, 16'd1, '0);
            end else begin
              depth_nxt = depth_r + 1'b1;
              mode_nxt  = M_BLOCK;
            end
          end else if (item.cls == CL_SLASH) begin
            mode_nxt = M_BSLASH;
          end else begin
            mode_nxt = M_BLOCK;
          end
        end
        M_BLOCK: begin
          if (item.cls == CL_STAR) begin
            mode_nxt = M_BSTAR;
          end else if (item.cls == CL_SLASH) begin
            mode_nxt = M_BSLASH;
          end else begin
            mode_nxt = M_BLOCK;
          end
        end
        default: begin
          mode_nxt   = M_IDLE;
          apply_idle = 1'b1;
        end
      endcase

      if (apply_idle) begin
        mode_nxt = idle_mode;
        s_v      = idle_emit;
        s_res    = idle_res;
        if (idle_start) begin
          tsc_nxt = col_r;
          len_nxt = 16'd1;
        end
        if (idle_num) begin
          acc_nxt = 31'(item.digit);
          ovf_nxt = 1'b0;
        end
      end

      if (item.cls == CL_NEWLINE) begin
        if (line_r != '1) begin
          line_nxt = line_r + 1'b1;
        end
        col_nxt = COLUMN_BITS'(1);
      end else if (col_r != '1) begin
        col_nxt = col_r + 1'b1;
      end

      halted_nxt = (p_v && p_res.error_code != E_NONE) ||
                   (s_v && s_res.error_code != E_NONE);
    end
  end

  always_comb begin
    res0_v = p_v || s_v;
    res1_v = p_v && s_v;
    res0   = p_v ? p_res : s_res;
    res1   = s_res;
    res1.last_of_run = 1'b1;
    res0.last_of_run = !res1_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      line_r   <= LINE_BITS'(1);
      col_r    <= COLUMN_BITS'(1);
      tsc_r    <= COLUMN_BITS'(1);
      len_r    <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      depth_r  <= '0;
      halted_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      tsc_r    <= tsc_nxt;
      len_r    <= len_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      depth_r  <= depth_nxt;
      halted_r <= halted_nxt;
    end
  end

  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !item.eos && halted_r) |-> !res0_v)
    else $error("result produced while halted on error");

  a_depth_in_comment: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_BLOCK || mode_r == M_BSTAR || mode_r == M_BSLASH) |-> depth_r != '0)
    else $error("inside block comment with zero depth");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.eos) |=> (mode_r == M_IDLE && !halted_r && depth_r == '0))
    else $error("scanner not back to idle after end of source");

endmodule

FILE: hw/rtl/c_subset_token_scanner.sv
// ----------------------------------------------------------------------------
// c_subset_token_scanner
// Streaming lexer for a small C-like language: classifier, item queue,
// scanner state machine and result queue.
// ----------------------------------------------------------------------------
// path: items are registered in the item queue, results in the result queue
// throughput: 1 item per cycle; the scanner waits while more than 2 results
//   sit in the result queue
// reset: synchronous active-low rst_n empties both queues and returns the
//   scanner to idle at line 1, column 1
module c_subset_token_scanner #(
  parameter int LINE_BITS         = 16,
  parameter int COLUMN_BITS       = 12,
  parameter int MAX_COMMENT_DEPTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_source,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_token_kind,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_start_line,
  output logic [11:0] out_start_column,
  output logic [15:0] out_token_length,
  output logic [30:0] out_number_value,
  output logic        out_last_of_run
);
  import cts_pkg::*;

  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 4;
  localparam int IN_CW     = $clog2(IN_DEPTH + 1);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  item_t               front_item, mid_item;
  logic [$bits(item_t)-1:0] mid_data;
  logic [IN_CW-1:0]    mid_count;
  logic [OUT_CW-1:0]   out_count;
  logic                in_xfer, item_pop, out_room;
  logic                res0_v, res1_v;
  res_t                res0, res1, out_res;
  logic [$bits(res_t)-1:0] out_data;

  assign in_full  = (mid_count == IN_CW'(IN_DEPTH));
  assign in_xfer  = in_push && !in_full;
  assign out_room = (out_count <= OUT_CW'(OUT_DEPTH - 2));
  assign mid_item = mid_data;
  assign out_res  = out_data;

  cts_front u_front (
    .char_code     (in_char_code),
    .end_of_source (in_end_of_source),
    .item          (front_item)
  );

  cts_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (IN_DEPTH)
  ) u_item_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en0   (in_xfer),
    .wr_data0 (front_item),
    .wr_en1   (1'b0),
    .wr_data1 ('0),
    .rd_en    (item_pop),
    .rd_data  (mid_data),
    .count    (mid_count)
  );

  cts_scanner #(
    .LINE_BITS         (LINE_BITS),
    .COLUMN_BITS       (COLUMN_BITS),
    .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
  ) u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (mid_count != '0),
    .item       (mid_item),
    .out_room   (out_room),
    .item_pop   (item_pop),
    .res0_v     (res0_v),
    .res0       (res0),
    .res1_v     (res1_v),
    .res1       (res1)
  );

  cts_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en0   (res0_v),
    .wr_data0 (res0),
    .wr_en1   (res1_v),
    .wr_data1 (res1),
    .rd_en    (out_pop && !out_empty),
    .rd_data  (out_data),
    .count    (out_count)
  );

  assign out_empty        = (out_count == '0);
  assign out_token_kind   = out_res.token_kind;
  assign out_error_code   = out_res.error_code;
  assign out_start_line   = out_res.start_line;
  assign out_start_column = out_res.start_column;
  assign out_token_length = out_res.token_length;
  assign out_number_value = out_res.number_value;
  assign out_last_of_run  = out_res.last_of_run;

endmodule
